// ----- rtl/i2r_pkg.sv -----
// Shared types, letter codes and the numeral symbol table for the Roman numeral converter.
package i2r_pkg;

   // Default input width and the cap on letters for one input beat
   localparam int VALUE_BITS_DEF = 12;
   localparam int MAX_RESULTS    = 16;
   localparam int COUNT_BITS     = $clog2(MAX_RESULTS);

   // Symbol table geometry
   localparam int SYM_COUNT      = 13;
   localparam int SYM_IDX_BITS   = $clog2(SYM_COUNT);
   localparam int AMOUNT_BITS    = 10;

   // ASCII letter codes
   localparam logic [6:0] CHR_M = 7'h4D;
   localparam logic [6:0] CHR_D = 7'h44;
   localparam logic [6:0] CHR_C = 7'h43;
   localparam logic [6:0] CHR_L = 7'h4C;
   localparam logic [6:0] CHR_X = 7'h58;
   localparam logic [6:0] CHR_V = 7'h56;
   localparam logic [6:0] CHR_I = 7'h49;
   localparam logic [6:0] CHR_NONE = 7'h00;

   typedef enum logic {
      CTL_IDLE,
      CTL_RUN
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } i2r_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic fin;
   } i2r_status_type;

   // One entry of the greedy symbol table
   typedef struct packed {
      logic [AMOUNT_BITS-1:0] amount;
      logic [6:0]             first;
      logic [6:0]             second;
      logic                   pair;
   } sym_type;

   // Look up a symbol, largest amount first
   function automatic sym_type sym_lookup(input logic [SYM_IDX_BITS-1:0] idx);
      sym_type s;
      s = '{amount: '0, first: CHR_I, second: CHR_NONE, pair: 1'b0};
      unique case (idx)
         4'd0:  s = '{amount: 10'd1000, first: CHR_M, second: CHR_NONE, pair: 1'b0};
         4'd1:  s = '{amount: 10'd900,  first: CHR_C, second: CHR_M,    pair: 1'b1};
         4'd2:  s = '{amount: 10'd500,  first: CHR_D, second: CHR_NONE, pair: 1'b0};
         4'd3:  s = '{amount: 10'd400,  first: CHR_C, second: CHR_D,    pair: 1'b1};
         4'd4:  s = '{amount: 10'd100,  first: CHR_C, second: CHR_NONE, pair: 1'b0};
         4'd5:  s = '{amount: 10'd90,   first: CHR_X, second: CHR_C,    pair: 1'b1};
         4'd6:  s = '{amount: 10'd50,   first: CHR_L, second: CHR_NONE, pair: 1'b0};
         4'd7:  s = '{amount: 10'd40,   first: CHR_X, second: CHR_L,    pair: 1'b1};
         4'd8:  s = '{amount: 10'd10,   first: CHR_X, second: CHR_NONE, pair: 1'b0};
         4'd9:  s = '{amount: 10'd9,    first: CHR_I, second: CHR_X,    pair: 1'b1};
         4'd10: s = '{amount: 10'd5,    first: CHR_V, second: CHR_NONE, pair: 1'b0};
         4'd11: s = '{amount: 10'd4,    first: CHR_I, second: CHR_V,    pair: 1'b1};
         4'd12: s = '{amount: 10'd1,    first: CHR_I, second: CHR_NONE, pair: 1'b0};
         default: s = '{amount: 10'd1,  first: CHR_I, second: CHR_NONE, pair: 1'b0};
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/i2r_ctrl.sv -----
// Controller state machine: accepts an input beat and paces the datapath steps.
module i2r_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output i2r_pkg::i2r_cmd_type   cmd,
   input  i2r_pkg::i2r_status_type status
);
   import i2r_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '{load: 1'b0, step: 1'b0};
      unique case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CTL_RUN;
            end
         end
         CTL_RUN: begin
            // advance only when the output slot can take a beat
            cmd.step = status.out_free;
            if (status.out_free && status.fin) begin
               state_in = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // Never step while idle
   a_no_step_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == CTL_IDLE |-> !cmd.step)
      else $error("step issued while idle");

   // Step only into a free output slot
   a_step_free: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> status.out_free)
      else $error("step issued into a full output slot");

   // Finishing step returns to idle
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.step && status.fin |=> state_ff == CTL_IDLE)
      else $error("controller missed end of item");

endmodule

// ----- rtl/i2r_dpath.sv -----
// Datapath: greedy symbol subtraction, letter counter and output register.
module i2r_dpath #(
   parameter int VALUE_BITS = i2r_pkg::VALUE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [VALUE_BITS-1:0]   req_value,
   input  i2r_pkg::i2r_cmd_type    cmd,
   output i2r_pkg::i2r_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [6:0]              rsp_letter,
   output logic                    rsp_char_valid,
   output logic                    rsp_last
);
   import i2r_pkg::*;

   localparam int CW = (VALUE_BITS > AMOUNT_BITS) ? VALUE_BITS : AMOUNT_BITS;

   // Working state of the current item
   logic [VALUE_BITS-1:0]   rem_ff, rem_in;
   logic [SYM_IDX_BITS-1:0] idx_ff, idx_in;
   logic                    second_ff, second_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   // Output register
   logic       valid_ff, valid_in;
   logic [6:0] letter_ff, letter_in;
   logic       cv_ff, cv_in;
   logic       last_ff, last_in;

   sym_type          sym;
   logic [CW-1:0]    rem_ext;
   logic [CW-1:0]    amt_ext;
   logic             fits;
   logic             cap;
   logic             emit;
   logic [6:0]       e_letter;
   logic             e_cv;
   logic             e_last;

   assign sym     = sym_lookup(idx_ff);
   assign rem_ext = CW'(rem_ff);
   assign amt_ext = CW'(sym.amount);
   assign fits    = rem_ext >= amt_ext;
   assign cap     = count_ff == COUNT_BITS'(MAX_RESULTS - 1);

   // Decide the next letter or a table advance
   always_comb begin
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      second_in = second_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      e_letter  = CHR_NONE;
      e_cv      = 1'b1;
      e_last    = 1'b0;
      if (second_ff) begin
         // second letter of a subtractive pair
         emit      = 1'b1;
         e_letter  = sym.second;
         e_last    = (rem_ff == '0) || cap;
         second_in = 1'b0;
      end else if (rem_ff == '0) begin
         // zero input: one empty beat
         emit   = 1'b1;
         e_cv   = 1'b0;
         e_last = 1'b1;
      end else if (fits) begin
         emit      = 1'b1;
         e_letter  = sym.first;
         rem_in    = VALUE_BITS'(rem_ext - amt_ext);
         second_in = sym.pair;
         e_last    = cap || (!sym.pair && rem_in == '0);
      end else begin
         idx_in = idx_ff + 1'b1;
      end
      if (emit) begin
         count_in = count_ff + 1'b1;
      end
      if (!cmd.step) begin
         rem_in    = rem_ff;
         idx_in    = idx_ff;
         second_in = second_ff;
         count_in  = count_ff;
      end
      if (cmd.load) begin
         rem_in    = req_value;
         idx_in    = '0;
         second_in = 1'b0;
         count_in  = '0;
      end
   end

   assign status.out_free = !valid_ff || rsp_ready;
   assign status.fin      = emit && e_last;

   // Load the output register on an emitting step, drop it when taken
   always_comb begin
      valid_in  = valid_ff && !rsp_ready;
      letter_in = letter_ff;
      cv_in     = cv_ff;
      last_in   = last_ff;
      if (cmd.step && emit) begin
         valid_in  = 1'b1;
         letter_in = e_letter;
         cv_in     = e_cv;
         last_in   = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
      rem_ff    <= rem_in;
      idx_ff    <= idx_in;
      count_ff  <= count_in;
      letter_ff <= letter_in;
      cv_ff     <= cv_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_letter     = letter_ff;
   assign rsp_char_valid = cv_ff;
   assign rsp_last       = last_ff;

   // An empty beat always closes its item
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !cv_ff |-> last_ff)
      else $error("empty beat without last");

   // A pending second letter is emitted on the next step
   a_pair_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.step && second_ff |=> valid_ff && cv_ff)
      else $error("second letter of pair lost");

   // Table advances never run past the last symbol while work remains
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step && rem_ff != '0 && !second_ff |-> idx_ff < SYM_IDX_BITS'(SYM_COUNT))
      else $error("symbol index out of range");

endmodule

// ----- rtl/integer_to_roman_numeral.sv -----
// Top level of the integer to Roman numeral converter.
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  req_value
//  rsp      out  rsp_valid/rsp_ready  rsp_letter, rsp_char_valid, rsp_last
//
// One input beat is taken, then the datapath walks a 13-entry symbol table,
// each cycle either sending one letter or moving to the next symbol.
// An item sends at most 16 letter beats.
// The output register lets the next input beat be taken while the last
// letter still waits; a stalled rsp side holds the walk in place.
// Reset empties the output register and returns the controller to idle.
module integer_to_roman_numeral #(
   parameter int VALUE_BITS = i2r_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [6:0]            rsp_letter,
   output logic                  rsp_char_valid,
   output logic                  rsp_last
);
   import i2r_pkg::*;

   i2r_cmd_type    cmd;
   i2r_status_type status;

   i2r_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   i2r_dpath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_letter     (rsp_letter),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the integer to Roman numeral converter.
module tb_top;
   import i2r_pkg::*;

   localparam int VB         = VALUE_BITS_DEF;
   localparam int DIR_ROWS   = 24;
   localparam int RAND_ITEMS = 480;
   localparam int HOLD_LEN   = 300;
   localparam int DRAIN_LEN  = 40;

   // One letter beat as seen on the rsp side
   typedef struct packed {
      logic [6:0] letter;
      logic       char_valid;
      logic       last;
   } numeral_beat_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [VB-1:0] req_value;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [6:0]    rsp_letter;
   logic          rsp_char_valid;
   logic          rsp_last;

   numeral_beat_type letters_due[$];
   int            mismatches;
   bit            no_idle;
   bit            rsp_hold_req;

   // Directed values; "?" rows go through the predictor, "" is the zero beat
   logic [VB-1:0] dir_value [DIR_ROWS] = '{
      12'd0,    12'd1,    12'd4095, 12'd3999, 12'd4000, 12'd4,    12'd9,    12'd5,
      12'd3,    12'd8,    12'd40,   12'd90,   12'd400,  12'd900,  12'd500,  12'd50,
      12'd1000, 12'd3888, 12'd444,  12'd999,  12'd1365, 12'd2730, 12'd2048, 12'd1444
   };
   string dir_roman [DIR_ROWS] = '{
      "",       "I",      "MMMMXCV", "MMMCMXCIX", "MMMM", "IV",     "IX",     "?",
      "?",      "?",      "?",       "?",         "?",    "?",      "?",      "?",
      "?",      "?",      "?",       "?",         "?",    "?",      "?",      "?"
   };

   integer_to_roman_numeral #(
      .VALUE_BITS(VB)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_letter    (rsp_letter),
      .rsp_char_valid(rsp_char_valid),
      .rsp_last      (rsp_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Pick an idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Queue the letter beats that one value should produce
   function automatic void predict_numeral(input logic [VB-1:0] v);
      logic [6:0] word [MAX_RESULTS];
      logic [6:0] unit, five, ten;
      int n, thousands, d;
      n = 0;
      if (v == '0) begin
         letters_due.push_back('{letter: CHR_NONE, char_valid: 1'b0, last: 1'b1});
         return;
      end
      thousands = int'(v) / 1000;
      for (int i = 0; i < thousands && n < MAX_RESULTS; i++) begin
         word[n] = CHR_M;
         n++;
      end
      // Hundreds, tens, ones, each over its unit/five/ten letters
      for (int place = 0; place < 3; place++) begin
         case (place)
            0: begin
               unit = CHR_C; five = CHR_D; ten = CHR_M; d = (int'(v) / 100) % 10;
            end
            1: begin
               unit = CHR_X; five = CHR_L; ten = CHR_C; d = (int'(v) / 10) % 10;
            end
            default: begin
               unit = CHR_I; five = CHR_V; ten = CHR_X; d = int'(v) % 10;
            end
         endcase
         if (d == 9 || d == 4) begin
            if (n < MAX_RESULTS) begin word[n] = unit; n++; end
            if (n < MAX_RESULTS) begin word[n] = (d == 9) ? ten : five; n++; end
         end else begin
            if (d >= 5) begin
               if (n < MAX_RESULTS) begin word[n] = five; n++; end
               d -= 5;
            end
            for (int k = 0; k < d; k++) begin
               if (n < MAX_RESULTS) begin word[n] = unit; n++; end
            end
         end
      end
      for (int i = 0; i < n; i++)
         letters_due.push_back('{letter: word[i], char_valid: 1'b1, last: (i == n - 1)});
   endfunction

   // Queue letter beats spelled out by hand; an empty word is the zero beat
   function automatic void queue_spelled(input string roman);
      byte ch;
      if (roman.len() == 0) begin
         letters_due.push_back('{letter: CHR_NONE, char_valid: 1'b0, last: 1'b1});
         return;
      end
      for (int i = 0; i < roman.len(); i++) begin
         ch = roman[i];
         letters_due.push_back('{letter: ch[6:0], char_valid: 1'b1,
                                 last: (i == roman.len() - 1)});
      end
   endfunction

   // Offer one value, hold it until the beat is taken
   task automatic send_value(input logic [VB-1:0] v, input string roman);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      if (roman == "?") predict_numeral(v);
      else queue_spelled(roman);
   endtask

   // Draw a random value, weighted toward small values and values built digit by digit
   function automatic logic [VB-1:0] pick_value();
      int r, t;
      r = $urandom_range(0, 99);
      if (r < 65) return VB'($urandom_range(0, 4095));
      if (r < 80) return VB'($urandom_range(0, 30));
      t = $urandom_range(0, 4) * 1000 + $urandom_range(0, 9) * 100
          + $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
      if (t > 4095) t = $urandom_range(3800, 4095);
      return VB'(t);
   endfunction

   // Main sequence: reset, directed table, random beats, drain, verdict
   initial begin
      mismatches   = 0;
      no_idle      = 1'b0;
      rsp_hold_req = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         send_value(dir_value[i], dir_roman[i]);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         // Stall the rsp side for a long stretch while beats keep coming
         if (i == 80) rsp_hold_req = 1'b1;
         // Pause the sender until every letter has come out
         if (i == 220) begin
            req_valid <= 1'b0;
            while (letters_due.size() != 0) @(posedge clock);
         end
         // Run a stretch with no idling on either side
         if (i == 300) no_idle = 1'b1;
         if (i == 360) no_idle = 1'b0;
         send_value(pick_value(), "?");
      end
      req_valid <= 1'b0;

      while (letters_due.size() != 0) @(posedge clock);
      repeat (DRAIN_LEN) @(posedge clock);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off counted here
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap();
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Check each letter beat against the oldest expectation
   always @(posedge clock) begin
      numeral_beat_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (letters_due.size() == 0) begin
            $error("unexpected letter beat: letter %h char_valid %b last %b",
                   rsp_letter, rsp_char_valid, rsp_last);
            mismatches++;
         end else begin
            due = letters_due.pop_front();
            if (rsp_letter !== due.letter) begin
               $error("letter: expected %h, got %h", due.letter, rsp_letter);
               mismatches++;
            end
            if (rsp_char_valid !== due.char_valid) begin
               $error("char_valid: expected %b, got %b", due.char_valid, rsp_char_valid);
               mismatches++;
            end
            if (rsp_last !== due.last) begin
               $error("last: expected %b, got %b", due.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      #30000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
